// File: sv/hsht_pkg.sv
// ---------------------------------------------------------------------------
// hsht_pkg
// shared types, constants and helpers of the hotness scoreboard hash table
// ---------------------------------------------------------------------------
`default_nettype none
package hsht_pkg;

  localparam int NUM_SLOTS = 4096;
  localparam int KEY_BYTES = 8;
  localparam int ADDR_W    = $clog2(NUM_SLOTS);
  localparam int CNT_W     = $clog2(NUM_SLOTS + 1);

  localparam logic [31:0] HASH_SEED   = 32'h9E3779B9;
  localparam logic [31:0] HASH_PRIME  = 32'h01000193;
  localparam logic [15:0] SCORE_ONE   = 16'd32768;
  localparam logic [15:0] SCORE_STEP  = 16'd1638;
  localparam logic [14:0] DECAY_MUL   = 15'd32604;
  localparam logic [15:0] SCORE_FLOOR = 16'd33;

  typedef enum logic [1:0] {
    FN_RECORD = 2'd0,
    FN_QUERY  = 2'd1,
    FN_DECAY  = 2'd2,
    FN_CLEAR  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_INSERTED = 3'd1,
    ST_FULL     = 3'd2,
    ST_EMPTYKEY = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  localparam logic [2:0] CLASS_RARE = 3'd4;

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_HASH, S_PRD, S_PCMP, S_DRD, S_DWR, S_CLR
  } state_t;

  typedef enum logic [2:0] {
    WR_NONE, WR_CLR, WR_DECAY, WR_INS, WR_UPD
  } wr_t;

  typedef enum logic [2:0] {
    EM_NONE, EM_OP, EM_EMPTY, EM_FAIL, EM_INS, EM_HIT
  } emit_t;

  typedef struct packed {
    logic  latch;
    logic  hash_step;
    logic  addr_zero;
    logic  adv;
    wr_t   wr;
    emit_t emit;
  } cmd_t;

  typedef struct packed {
    logic in_empty;
    logic hash_last;
    logic row_valid;
    logic key_match;
    logic is_record;
    logic probe_last;
    logic addr_last;
    logic cnt_full;
  } sts_t;

  function automatic logic [2:0] classify(input logic [15:0] s);
    logic [2:0] c;
    if (s > 16'd26247)     c = 3'd0;
    else if (s > 16'd19693) c = 3'd1;
    else if (s > 16'd8224)  c = 3'd2;
    else if (s > 16'd3244)  c = 3'd3;
    else                    c = CLASS_RARE;
    return c;
  endfunction

  // keep bytes before the first zero byte
  function automatic logic [63:0] key_norm(input logic [63:0] k);
    logic [63:0] r;
    logic        stop;
    r    = '0;
    stop = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (k[8*i +: 8] == 8'd0 || i >= KEY_BYTES) stop = 1'b1;
      if (!stop) r[8*i +: 8] = k[8*i +: 8];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: sv/hsht_ctrl.sv
// ---------------------------------------------------------------------------
// hsht_ctrl
// sequencer for hashing, probing and table sweeps
// ---------------------------------------------------------------------------
`default_nettype none
module hsht_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [1:0]    in_func,
  input  wire hsht_pkg::sts_t sts,
  output hsht_pkg::cmd_t     cmd,
  output logic               busy
);
  import hsht_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_INIT;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_INIT: if (sts.addr_last) state_nxt = S_IDLE;
      S_IDLE: begin
        if (start) begin
          if (in_func == FN_DECAY)      state_nxt = S_DRD;
          else if (in_func == FN_CLEAR) state_nxt = S_CLR;
          else if (!sts.in_empty)       state_nxt = S_HASH;
        end
      end
      S_HASH: if (sts.hash_last) state_nxt = S_PRD;
      S_PRD:  state_nxt = S_PCMP;
      S_PCMP: begin
        if (!sts.row_valid || sts.key_match || sts.probe_last) state_nxt = S_IDLE;
        else                                                  state_nxt = S_PRD;
      end
      S_DRD:  state_nxt = S_DWR;
      S_DWR:  state_nxt = sts.addr_last ? S_IDLE : S_DRD;
      S_CLR:  if (sts.addr_last) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '{latch: 1'b0, hash_step: 1'b0, addr_zero: 1'b0, adv: 1'b0,
             wr: WR_NONE, emit: EM_NONE};
    busy = (state_r != S_IDLE);
    case (state_r)
      S_INIT: begin
        cmd.wr  = WR_CLR;
        cmd.adv = 1'b1;
      end
      S_IDLE: begin
        if (start) begin
          cmd.latch     = 1'b1;
          cmd.addr_zero = 1'b1;
          if (in_func != FN_DECAY && in_func != FN_CLEAR && sts.in_empty)
            cmd.emit = EM_EMPTY;
        end
      end
      S_HASH: cmd.hash_step = 1'b1;
      S_PCMP: begin
        if (!sts.row_valid) begin
          if (sts.is_record && !sts.cnt_full) begin
            cmd.wr   = WR_INS;
            cmd.emit = EM_INS;
          end else begin
            cmd.emit = EM_FAIL;
          end
        end else if (sts.key_match) begin
          if (sts.is_record) cmd.wr = WR_UPD;
          cmd.emit = EM_HIT;
        end else if (sts.probe_last) begin
          cmd.emit = EM_FAIL;
        end else begin
          cmd.adv = 1'b1;
        end
      end
      S_DWR: begin
        cmd.wr = WR_DECAY;
        if (sts.addr_last) cmd.emit = EM_OP;
        else               cmd.adv  = 1'b1;
      end
      S_CLR: begin
        cmd.wr  = WR_CLR;
        cmd.adv = 1'b1;
        if (sts.addr_last) cmd.emit = EM_OP;
      end
      default: ;
    endcase
  end

  a_emit_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit != EM_NONE) |=> state_r == S_IDLE) else $error("emit not final");
  a_cmp_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PCMP) |-> $past(state_r) == S_PRD) else $error("compare w/o read");
  a_idle_no_wr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> cmd.wr == WR_NONE) else $error("write while idle");

endmodule
`default_nettype wire

// File: sv/hsht_dp.sv
// ---------------------------------------------------------------------------
// hsht_dp
// hash unit, slot memory, entry update and result registers
// ---------------------------------------------------------------------------
`default_nettype none
module hsht_dp (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic [1:0]     in_func,
  input  wire logic [63:0]    in_key,
  input  wire logic [47:0]    in_time_ms,
  input  wire hsht_pkg::cmd_t cmd,
  output hsht_pkg::sts_t      sts,
  output logic                out_valid,
  output logic [2:0]          out_status,
  output logic [11:0]         out_slot_index,
  output logic [2:0]          out_hotness_class,
  output logic [15:0]         out_score,
  output logic [31:0]         out_hits
);
  import hsht_pkg::*;

  localparam int ROW_W = 1 + 64 + 16 + 32 + 48;

  logic [ROW_W-1:0]  mem [NUM_SLOTS];
  logic [ROW_W-1:0]  rd_r;
  logic [ROW_W-1:0]  wdata;
  logic [63:0]       key_r;
  logic [47:0]       time_r;
  logic [1:0]        func_r;
  logic [31:0]       h_r, h_nxt;
  logic [2:0]        bi_r;
  logic [ADDR_W-1:0] addr_r;
  logic [CNT_W-1:0]  cnt_r, ecount_r;
  logic [63:0]       key_n;
  logic [7:0]        cur_b;

  logic              rv;
  logic [63:0]       rkey;
  logic [15:0]       rscore;
  logic [31:0]       rhits;
  logic [16:0]       sc_sum;
  logic [15:0]       sc_upd, sc_dec;
  logic [30:0]       dec_prod;
  logic [31:0]       hits_upd;

  logic              ov_r;
  logic [2:0]        ost_r, ocl_r;
  logic [11:0]       osl_r;
  logic [15:0]       osc_r;
  logic [31:0]       oh_r;

  assign key_n = key_norm(in_key);
  assign cur_b = key_r[8*bi_r +: 8];
  assign h_nxt = (h_r ^ {24'd0, cur_b}) * HASH_PRIME;

  assign {rv, rkey, rscore, rhits} = rd_r[ROW_W-1:48];

  assign sc_sum   = {1'b0, rscore} + {1'b0, SCORE_STEP};
  assign sc_upd   = (sc_sum > {1'b0, SCORE_ONE}) ? SCORE_ONE : sc_sum[15:0];
  assign hits_upd = (rhits == 32'hFFFF_FFFF) ? rhits : rhits + 32'd1;
  assign dec_prod = rscore * DECAY_MUL;
  assign sc_dec   = ({1'b0, dec_prod[30:15]} < {1'b0, SCORE_FLOOR}) ?
                    SCORE_FLOOR : dec_prod[30:15];

  always_comb begin
    sts.in_empty   = (key_n[7:0] == 8'd0);
    sts.hash_last  = (bi_r == 3'd7) || (key_r[8*(bi_r+3'd1) +: 8] == 8'd0);
    sts.row_valid  = rv;
    sts.key_match  = (rkey == key_r);
    sts.is_record  = (func_r == FN_RECORD);
    sts.probe_last = (cnt_r == CNT_W'(NUM_SLOTS - 1));
    sts.addr_last  = (addr_r == ADDR_W'(NUM_SLOTS - 1));
    sts.cnt_full   = (ecount_r >= CNT_W'(NUM_SLOTS));
  end

  always_comb begin
    case (cmd.wr)
      WR_INS:   wdata = {1'b1, key_r, SCORE_ONE, 32'd1, time_r};
      WR_UPD:   wdata = {1'b1, key_r, sc_upd, hits_upd, time_r};
      WR_DECAY: wdata = {rv, rkey, (rv ? sc_dec : rscore), rd_r[79:0]};
      default:  wdata = '0;
    endcase
  end

  // slot memory, one read and one write port
  always_ff @(posedge clk) begin
    rd_r <= mem[addr_r];
    if (cmd.wr != WR_NONE) mem[addr_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      key_r  <= key_n;
      time_r <= in_time_ms;
      func_r <= in_func;
      h_r    <= HASH_SEED;
      bi_r   <= '0;
    end else if (cmd.hash_step) begin
      h_r  <= h_nxt;
      bi_r <= bi_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r   <= '0;
      cnt_r    <= '0;
      ecount_r <= '0;
    end else begin
      if (cmd.addr_zero) begin
        addr_r <= '0;
        cnt_r  <= '0;
      end else if (cmd.hash_step && sts.hash_last) begin
        addr_r <= h_nxt[ADDR_W-1:0];
        cnt_r  <= '0;
      end else if (cmd.adv) begin
        addr_r <= addr_r + ADDR_W'(1);
        cnt_r  <= cnt_r + CNT_W'(1);
      end
      if (cmd.wr == WR_CLR)      ecount_r <= '0;
      else if (cmd.wr == WR_INS) ecount_r <= ecount_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else        ov_r <= (cmd.emit != EM_NONE);
  end

  always_ff @(posedge clk) begin
    ost_r <= ST_OK;
    osl_r <= '0;
    ocl_r <= CLASS_RARE;
    osc_r <= '0;
    oh_r  <= '0;
    case (cmd.emit)
      EM_EMPTY: ost_r <= ST_EMPTYKEY;
      EM_FAIL:  ost_r <= (func_r == FN_RECORD) ? ST_FULL : ST_NOTFOUND;
      EM_INS: begin
        ost_r <= ST_INSERTED;
        osl_r <= 12'(addr_r);
        ocl_r <= classify(SCORE_ONE);
        osc_r <= SCORE_ONE;
        oh_r  <= 32'd1;
      end
      EM_HIT: begin
        osl_r <= 12'(addr_r);
        if (func_r == FN_RECORD) begin
          ocl_r <= classify(sc_upd);
          osc_r <= sc_upd;
          oh_r  <= hits_upd;
        end else begin
          ocl_r <= classify(rscore);
          osc_r <= rscore;
          oh_r  <= rhits;
        end
      end
      default: ;
    endcase
  end

  assign out_valid         = ov_r;
  assign out_status        = ost_r;
  assign out_slot_index    = osl_r;
  assign out_hotness_class = ocl_r;
  assign out_score         = osc_r;
  assign out_hits          = oh_r;

endmodule
`default_nettype wire

// File: sv/hotness_scoreboard_hash_table.sv
// ---------------------------------------------------------------------------
// hotness_scoreboard_hash_table
// linear probing table of access-hotness entries
// ---------------------------------------------------------------------------
// an item is taken when start is high and busy low; its result appears one
// cycle on the out_ ports with out_valid and cannot be stalled. after reset
// the block clears every slot of the slot memory with busy high. record
// and query hash the key's bytes (1 to 8) through the one-byte-per-cycle
// hash multiply, then read and compare each probed slot in turn; an empty
// key is answered without hashing, its result registered as the item is
// taken. decay reads and rewrites each slot in turn, clear writes each
// slot in turn, both beginning once the item is taken
// ---------------------------------------------------------------------------
`default_nettype none
module hotness_scoreboard_hash_table (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_func,
  input  wire logic [63:0] in_key,
  input  wire logic [47:0] in_time_ms,
  output logic             out_valid,
  output logic [2:0]       out_status,
  output logic [11:0]      out_slot_index,
  output logic [2:0]       out_hotness_class,
  output logic [15:0]      out_score,
  output logic [31:0]      out_hits
);
  import hsht_pkg::*;

  cmd_t cmd;   // sequencer commands
  sts_t sts;   // datapath status

  hsht_ctrl u_ctrl (
    .clk, .rst_n, .start, .in_func, .sts, .cmd, .busy
  );

  // memory, hash and result registers
  hsht_dp u_dp (
    .clk, .rst_n, .in_func, .in_key, .in_time_ms, .cmd, .sts,
    .out_valid, .out_status, .out_slot_index, .out_hotness_class,
    .out_score, .out_hits
  );

endmodule
`default_nettype wire
